/* hw/rtl/pdb_pkg.sv */
`default_nettype none

package pdb_pkg;

  // Field widths of the event and result items.
  localparam int OP_W      = 2;
  localparam int TIME_W    = 32;
  localparam int BYTES_W   = 24;
  localparam int RATE_W    = 16;
  localparam int DEBT_W    = 25;
  localparam int INFL_W    = 32;
  localparam int CWIN_W    = 32;
  localparam int PAYOFF_W  = 16;

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // Leaky-bucket time constants in milliseconds.
  localparam int MAX_DEBT_MS    = 500;
  localparam int MAX_ELAPSED_MS = 2000;

  // Width of the clamped elapsed time and of the multiplier's second operand.
  localparam int ELAPSED_W = $clog2(MAX_ELAPSED_MS + 1);
  localparam int DEBT_MS_W = $clog2(MAX_DEBT_MS + 1);
  localparam int FACT_W    = (ELAPSED_W > DEBT_MS_W) ? ELAPSED_W : DEBT_MS_W;
  localparam int PROD_W    = RATE_W + FACT_W;

  // Working width for debt arithmetic: holds a product and a debt plus bytes.
  localparam int SUM_W = (PROD_W > DEBT_W + 1) ? PROD_W : DEBT_W + 1;

  // Divider step counter.
  localparam int DIV_CNT_W = $clog2(DEBT_W + 1);

  localparam logic [DEBT_W-1:0]   DEBT_MAX   = {DEBT_W{1'b1}};
  localparam logic [PAYOFF_W-1:0] PAYOFF_MAX = {PAYOFF_W{1'b1}};

  typedef enum logic [OP_W-1:0] {
    OP_ADVANCE  = 2'd0,
    OP_MEDIA    = 2'd1,
    OP_PADDING  = 2'd2,
    OP_INFLIGHT = 2'd3
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MEDIA_RATE   = 2'd0,
    CFG_PADDING_RATE = 2'd1,
    CFG_CONG_WINDOW  = 2'd2,
    CFG_COUNT_AUDIO  = 2'd3
  } cfg_idx_e;

endpackage

`default_nettype wire

/* hw/rtl/pdb_if.sv */
`default_nettype none

// Event channel into the pacer budget.
interface pdb_in_if;
  logic                         valid;
  logic                         ready;
  logic [pdb_pkg::OP_W-1:0]     opcode;
  logic [pdb_pkg::TIME_W-1:0]   now_ms;
  logic [pdb_pkg::BYTES_W-1:0]  byte_count;
  logic                         is_audio;

  modport source (output valid, opcode, now_ms, byte_count, is_audio, input ready);
  modport sink   (input valid, opcode, now_ms, byte_count, is_audio, output ready);
endinterface

// Result channel out of the pacer budget.
interface pdb_out_if;
  logic                          valid;
  logic                          ready;
  logic [pdb_pkg::DEBT_W-1:0]    media_debt_out;
  logic [pdb_pkg::DEBT_W-1:0]    padding_debt_out;
  logic                          congested;
  logic [pdb_pkg::PAYOFF_W-1:0]  media_payoff_ms;
  logic [pdb_pkg::PAYOFF_W-1:0]  padding_payoff_ms;

  modport source (output valid, media_debt_out, padding_debt_out, congested,
                  media_payoff_ms, padding_payoff_ms, input ready);
  modport sink   (input valid, media_debt_out, padding_debt_out, congested,
                  media_payoff_ms, padding_payoff_ms, output ready);
endinterface

`default_nettype wire

/* hw/rtl/pacing_debt_budget.sv */
// Pacing debt budget: keeps the media and padding leaky-bucket debts of a
// packet pacer and reports, for every event item, both debts, the congestion
// flag and the milliseconds needed to pay off each debt. The block takes one
// item at a time and drops ready until its result is loaded into the output
// register. After an item is accepted it passes through a preparation step,
// a multiply and an update step for each debt when the debts change (one
// shared 16 by 11-bit multiplier), a division for each nonzero rate in the
// shared one-bit-per-cycle divider (a zero rate skips it) and a final step
// that loads the result. A pending result that has not been taken delays the
// load but not the acceptance of the next item. The user must write rates,
// the congestion window and the audio switch through the configuration port
// only while the block is idle; the block itself does not enforce this.

`default_nettype none

module pacing_debt_budget (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [pdb_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire logic [pdb_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  pdb_in_if.sink                                in_if,
  pdb_out_if.source                             out_if
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_MUL,
    S_UPD,
    S_DIV_GO,
    S_DIV_WAIT,
    S_DONE
  } state_e;

  // Configuration registers.
  logic [pdb_pkg::RATE_W-1:0]  media_rate_q;
  logic [pdb_pkg::RATE_W-1:0]  padding_rate_q;
  logic [pdb_pkg::CWIN_W-1:0]  cwin_q;
  logic                        count_audio_q;

  // Latched item.
  pdb_pkg::op_e                op_q;
  logic [pdb_pkg::TIME_W-1:0]  now_q;
  logic [pdb_pkg::BYTES_W-1:0] bytes_q;
  logic                        audio_q;

  // Bucket state.
  logic [pdb_pkg::DEBT_W-1:0]  media_debt_q;
  logic [pdb_pkg::DEBT_W-1:0]  padding_debt_q;
  logic [pdb_pkg::INFL_W-1:0]  infl_q;
  logic [pdb_pkg::TIME_W-1:0]  last_proc_q;
  logic [pdb_pkg::TIME_W-1:0]  last_send_q;

  // Sequencer and working registers.
  state_e                        state_q;
  logic                          side_q;
  logic                          do_drain_q;
  logic [pdb_pkg::ELAPSED_W-1:0] elapsed_q;
  logic [pdb_pkg::PROD_W-1:0]    prod_q;
  logic [pdb_pkg::PAYOFF_W-1:0]  media_payoff_q;
  logic [pdb_pkg::PAYOFF_W-1:0]  padding_payoff_q;

  // Output register.
  logic                          out_valid_q;
  logic [pdb_pkg::DEBT_W-1:0]    out_media_debt_q;
  logic [pdb_pkg::DEBT_W-1:0]    out_padding_debt_q;
  logic                          out_congested_q;
  logic [pdb_pkg::PAYOFF_W-1:0]  out_media_payoff_q;
  logic [pdb_pkg::PAYOFF_W-1:0]  out_padding_payoff_q;

  logic                          in_accept;
  logic                          out_free;

  // Operand selection for the shared multiplier and divider.
  logic [pdb_pkg::RATE_W-1:0]    rate_sel;
  logic [pdb_pkg::DEBT_W-1:0]    debt_sel;
  logic [pdb_pkg::FACT_W-1:0]    factor;
  logic [pdb_pkg::PROD_W-1:0]    mul_res;

  // Debt update from the registered product.
  logic [pdb_pkg::SUM_W-1:0]     ext_debt;
  logic [pdb_pkg::SUM_W-1:0]     ext_prod;
  logic [pdb_pkg::SUM_W-1:0]     sum;
  logic [pdb_pkg::SUM_W-1:0]     limit;
  logic [pdb_pkg::DEBT_W-1:0]    drained;
  logic [pdb_pkg::DEBT_W-1:0]    added;
  logic [pdb_pkg::DEBT_W-1:0]    new_debt;

  // Event decode.
  logic [pdb_pkg::TIME_W-1:0]    elapsed_full;
  logic [pdb_pkg::ELAPSED_W-1:0] elapsed_clamp;
  logic                          time_ok;
  logic                          cong_before;
  logic                          cong_new_infl;
  logic                          cong_now;
  logic [pdb_pkg::INFL_W:0]      infl_sum;
  logic [pdb_pkg::INFL_W-1:0]    infl_sat;

  // Divider.
  logic                          div_start;
  logic                          div_done;
  logic [pdb_pkg::DEBT_W-1:0]    div_quo;
  logic [pdb_pkg::PAYOFF_W-1:0]  payoff_sat;

  assign in_accept = in_if.valid && in_if.ready;
  assign out_free  = !out_valid_q || out_if.ready;

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      media_rate_q   <= '0;
      padding_rate_q <= '0;
      cwin_q         <= '0;
      count_audio_q  <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (pdb_pkg::cfg_idx_e'(cfg_idx_i))
        pdb_pkg::CFG_MEDIA_RATE:   media_rate_q   <= cfg_data_i[pdb_pkg::RATE_W-1:0];
        pdb_pkg::CFG_PADDING_RATE: padding_rate_q <= cfg_data_i[pdb_pkg::RATE_W-1:0];
        pdb_pkg::CFG_CONG_WINDOW:  cwin_q         <= cfg_data_i[pdb_pkg::CWIN_W-1:0];
        pdb_pkg::CFG_COUNT_AUDIO:  count_audio_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Shared multiplier operands: rate times elapsed time, or rate times the cap.
  always_comb begin
    rate_sel = side_q ? padding_rate_q : media_rate_q;
    debt_sel = side_q ? padding_debt_q : media_debt_q;
    factor   = do_drain_q ? pdb_pkg::FACT_W'(elapsed_q)
                          : pdb_pkg::FACT_W'(pdb_pkg::MAX_DEBT_MS);
    mul_res  = pdb_pkg::PROD_W'(rate_sel) * pdb_pkg::PROD_W'(factor);
  end

  // Drain floors at zero; add is capped by the product and the debt maximum.
  always_comb begin
    ext_debt = pdb_pkg::SUM_W'(debt_sel);
    ext_prod = pdb_pkg::SUM_W'(prod_q);
    drained  = (ext_prod >= ext_debt) ? '0
                                      : pdb_pkg::DEBT_W'(ext_debt - ext_prod);
    sum      = ext_debt + pdb_pkg::SUM_W'(bytes_q);
    limit    = (ext_prod < pdb_pkg::SUM_W'(pdb_pkg::DEBT_MAX)) ? ext_prod
                                                               : pdb_pkg::SUM_W'(pdb_pkg::DEBT_MAX);
    added    = pdb_pkg::DEBT_W'((sum > limit) ? limit : sum);
    new_debt = do_drain_q ? drained : added;
  end

  // Elapsed time, congestion checks and in-flight accumulation.
  always_comb begin
    time_ok       = now_q >= last_proc_q;
    elapsed_full  = now_q - last_proc_q;
    elapsed_clamp = (elapsed_full > pdb_pkg::TIME_W'(pdb_pkg::MAX_ELAPSED_MS))
                    ? pdb_pkg::ELAPSED_W'(pdb_pkg::MAX_ELAPSED_MS)
                    : elapsed_full[pdb_pkg::ELAPSED_W-1:0];
    cong_before   = (cwin_q != '0) && (infl_q >= cwin_q);
    cong_new_infl = (cwin_q != '0) && (pdb_pkg::CWIN_W'(bytes_q) >= cwin_q);
    cong_now      = cong_before;
    infl_sum      = {1'b0, infl_q} + (pdb_pkg::INFL_W + 1)'(bytes_q);
    infl_sat      = infl_sum[pdb_pkg::INFL_W] ? '1 : infl_sum[pdb_pkg::INFL_W-1:0];
  end

  // Divider start and quotient saturation.
  assign div_start  = (state_q == S_DIV_GO) && (rate_sel != '0);
  assign payoff_sat = (div_quo[pdb_pkg::DEBT_W-1:pdb_pkg::PAYOFF_W] != '0)
                      ? pdb_pkg::PAYOFF_MAX : div_quo[pdb_pkg::PAYOFF_W-1:0];

  pdb_div u_pdb_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (debt_sel),
    .divisor_i  (rate_sel),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  // Sequencer with bucket state and the output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      side_q         <= 1'b0;
      do_drain_q     <= 1'b0;
      out_valid_q    <= 1'b0;
      media_debt_q   <= '0;
      padding_debt_q <= '0;
      infl_q         <= '0;
      last_proc_q    <= '0;
      last_send_q    <= '0;
    end else begin
      // A taken result clears the output unless a new one is loaded now.
      if (out_valid_q && out_if.ready && (state_q != S_DONE)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_accept) begin
            op_q    <= pdb_pkg::op_e'(in_if.opcode);
            now_q   <= in_if.now_ms;
            bytes_q <= in_if.byte_count;
            audio_q <= in_if.is_audio;
            state_q <= S_PREP;
          end
        end
        S_PREP: begin
          side_q    <= 1'b0;
          elapsed_q <= elapsed_clamp;
          unique case (op_q)
            pdb_pkg::OP_ADVANCE: begin
              do_drain_q <= time_ok;
              if (time_ok) begin
                last_proc_q <= now_q;
                state_q     <= S_MUL;
              end else begin
                state_q     <= S_DIV_GO;
              end
            end
            pdb_pkg::OP_MEDIA: begin
              do_drain_q  <= 1'b0;
              last_send_q <= now_q;
              last_proc_q <= now_q;
              if (!audio_q || count_audio_q) begin
                infl_q  <= infl_sat;
                state_q <= S_MUL;
              end else begin
                state_q <= S_DIV_GO;
              end
            end
            pdb_pkg::OP_PADDING: begin
              do_drain_q  <= 1'b0;
              last_send_q <= now_q;
              last_proc_q <= now_q;
              if (bytes_q != '0) begin
                infl_q  <= infl_sat;
                state_q <= S_MUL;
              end else begin
                state_q <= S_DIV_GO;
              end
            end
            pdb_pkg::OP_INFLIGHT: begin
              infl_q     <= pdb_pkg::INFL_W'(bytes_q);
              do_drain_q <= cong_now && !cong_new_infl && time_ok;
              if (cong_now && !cong_new_infl && time_ok) begin
                last_proc_q <= now_q;
                state_q     <= S_MUL;
              end else begin
                state_q     <= S_DIV_GO;
              end
            end
            default: state_q <= S_DIV_GO;
          endcase
        end
        S_MUL: begin
          prod_q  <= mul_res;
          state_q <= S_UPD;
        end
        S_UPD: begin
          if (side_q) begin
            padding_debt_q <= new_debt;
            side_q         <= 1'b0;
            state_q        <= S_DIV_GO;
          end else begin
            media_debt_q <= new_debt;
            side_q       <= 1'b1;
            state_q      <= S_MUL;
          end
        end
        S_DIV_GO: begin
          if (rate_sel != '0) begin
            state_q <= S_DIV_WAIT;
          end else begin
            // A zero rate pays off in zero time.
            if (side_q) begin
              padding_payoff_q <= '0;
              state_q          <= S_DONE;
            end else begin
              media_payoff_q <= '0;
              side_q         <= 1'b1;
            end
          end
        end
        S_DIV_WAIT: begin
          if (div_done) begin
            if (side_q) begin
              padding_payoff_q <= payoff_sat;
              state_q          <= S_DONE;
            end else begin
              media_payoff_q <= payoff_sat;
              side_q         <= 1'b1;
              state_q        <= S_DIV_GO;
            end
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_valid_q          <= 1'b1;
            out_media_debt_q     <= media_debt_q;
            out_padding_debt_q   <= padding_debt_q;
            out_congested_q      <= cong_now;
            out_media_payoff_q   <= media_payoff_q;
            out_padding_payoff_q <= padding_payoff_q;
            state_q              <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_if.ready              = (state_q == S_IDLE);
  assign out_if.valid             = out_valid_q;
  assign out_if.media_debt_out    = out_media_debt_q;
  assign out_if.padding_debt_out  = out_padding_debt_q;
  assign out_if.congested         = out_congested_q;
  assign out_if.media_payoff_ms   = out_media_payoff_q;
  assign out_if.padding_payoff_ms = out_padding_payoff_q;

endmodule

`default_nettype wire

/* hw/rtl/pdb_div.sv */
`default_nettype none

// Restoring divider, one quotient bit per cycle. A start pulse loads the
// operands; done pulses for one cycle when the quotient is ready.
module pdb_div (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  input  wire logic [pdb_pkg::DEBT_W-1:0]   dividend_i,
  input  wire logic [pdb_pkg::RATE_W-1:0]   divisor_i,
  output logic                              done_o,
  output logic [pdb_pkg::DEBT_W-1:0]        quotient_o
);

  logic                              busy_q;
  logic                              done_q;
  logic [pdb_pkg::DIV_CNT_W-1:0]     cnt_q;
  logic [pdb_pkg::RATE_W-1:0]        rem_q, rem_d;
  logic [pdb_pkg::DEBT_W-1:0]        quo_q, quo_d;
  logic [pdb_pkg::RATE_W-1:0]        divisor_q;
  logic [pdb_pkg::RATE_W:0]          shifted;
  logic [pdb_pkg::RATE_W:0]          diff;
  logic                              fits;

  // One trial subtraction of the divisor from the shifted remainder.
  always_comb begin
    shifted = {rem_q, quo_q[pdb_pkg::DEBT_W-1]};
    diff    = shifted - {1'b0, divisor_q};
    fits    = shifted >= {1'b0, divisor_q};
    rem_d   = fits ? diff[pdb_pkg::RATE_W-1:0] : shifted[pdb_pkg::RATE_W-1:0];
    quo_d   = {quo_q[pdb_pkg::DEBT_W-2:0], fits};
  end

  // Control: step counter and completion pulse.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= pdb_pkg::DIV_CNT_W'(pdb_pkg::DEBT_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - pdb_pkg::DIV_CNT_W'(1);
        if (cnt_q == pdb_pkg::DIV_CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath: remainder and quotient shift register.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q     <= '0;
      quo_q     <= dividend_i;
      divisor_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

`default_nettype wire

/* hw/rtl/pdb_checker.sv */
`default_nettype none

// Port-level checks for the pacer budget.
module pdb_checker (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             in_valid_i,
  input  wire logic                             in_ready_i,
  input  wire logic                             out_valid_i,
  input  wire logic                             out_ready_i,
  input  wire logic [pdb_pkg::DEBT_W-1:0]       media_debt_i,
  input  wire logic [pdb_pkg::DEBT_W-1:0]       padding_debt_i,
  input  wire logic                             congested_i,
  input  wire logic [pdb_pkg::PAYOFF_W-1:0]     media_payoff_i,
  input  wire logic [pdb_pkg::PAYOFF_W-1:0]     padding_payoff_i
);

  logic       in_acc;
  logic       out_acc;
  logic [1:0] pend_q;

  assign in_acc  = in_valid_i && in_ready_i;
  assign out_acc = out_valid_i && out_ready_i;

  // Items accepted whose result has not yet been taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else if (in_acc && !out_acc) begin
      pend_q <= pend_q + 2'd1;
    end else if (out_acc && !in_acc) begin
      pend_q <= pend_q - 2'd1;
    end
  end

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result withdrawn while stalled");

  // A stalled result keeps its payload.
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(media_debt_i) && $stable(padding_debt_i)
      && $stable(congested_i) && $stable(media_payoff_i) && $stable(padding_payoff_i))
    else $error("result payload changed while stalled");

  // The block works on one item at a time.
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !in_ready_i)
    else $error("item accepted while another is in work");

  // No result appears without an accepted item behind it.
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> pend_q != 2'd0)
    else $error("result without an accepted item");

  // A zero debt pays off in zero time.
  a_zero_payoff: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (media_debt_i != '0 || media_payoff_i == '0)
      && (padding_debt_i != '0 || padding_payoff_i == '0))
    else $error("nonzero payoff for zero debt");

endmodule

bind pacing_debt_budget pdb_checker u_pdb_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_if.valid),
  .in_ready_i       (in_if.ready),
  .out_valid_i      (out_if.valid),
  .out_ready_i      (out_if.ready),
  .media_debt_i     (out_if.media_debt_out),
  .padding_debt_i   (out_if.padding_debt_out),
  .congested_i      (out_if.congested),
  .media_payoff_i   (out_if.media_payoff_ms),
  .padding_payoff_i (out_if.padding_payoff_ms)
);

`default_nettype wire
